/* src/raster_primitive_engine_top_macros.svh */
// Assertion macros shared by the raster primitive engine RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RASTER_PRIMITIVE_ENGINE_TOP_MACROS_SVH
`define RASTER_PRIMITIVE_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RPE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define RPE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RPE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RPE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/rpe_pkg.sv */
// Types and constants of the raster primitive engine.
// No dependencies; used by every module of the engine.
`timescale 1ns / 1ps

package rpe_pkg;

    localparam int COORD_BITS = 12;
    localparam int ADDR_BITS  = 17;
    localparam int COLOR_BITS = 16;
    localparam int PADDR_BITS = 3;
    // internal coordinate, error and decision widths
    localparam int CW = COORD_BITS + 2;
    localparam int EW = COORD_BITS + 4;
    localparam int DW = COORD_BITS + 8;

    localparam logic [COLOR_BITS-1:0] CLEAR_COLOR = 16'hFFFF;
    localparam logic [COLOR_BITS-1:0] RESET_COLOR = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_STEP    = 3'd0,
        MODE_LINE    = 3'd1,
        MODE_CIRCLE  = 3'd2,
        MODE_OUTLINE = 3'd3,
        MODE_RECT    = 3'd4,
        MODE_FILL    = 3'd5,
        MODE_CLEAR   = 3'd6,
        MODE_UNUSED  = 3'd7
    } mode_t;

    typedef enum logic [4:0] {
        K_IDLE    = 5'b00001,
        K_LINE    = 5'b00010,
        K_CIRCLE  = 5'b00100,
        K_OUTLINE = 5'b01000,
        K_SCAN    = 5'b10000
    } shape_t;

    typedef struct packed {
        logic [2:0]                   mode;
        logic signed [COORD_BITS-1:0] row_a;
        logic signed [COORD_BITS-1:0] col_a;
        logic signed [COORD_BITS-1:0] row_b;
        logic signed [COORD_BITS-1:0] col_b;
        logic signed [COORD_BITS-1:0] radius;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  pixel_address;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  write_enable;
        logic                  last_pixel;
    } pixel_t;

    typedef struct packed {
        mode_t                        op;
        logic signed [COORD_BITS-1:0] row_a;
        logic signed [COORD_BITS-1:0] col_a;
        logic signed [COORD_BITS-1:0] row_b;
        logic signed [COORD_BITS-1:0] col_b;
        logic signed [COORD_BITS-1:0] radius;
    } cmd_t;

    typedef struct packed {
        logic signed [CW-1:0] cur_r;
        logic signed [CW-1:0] cur_c;
        logic signed [CW-1:0] end_r;
        logic signed [CW-1:0] end_c;
        logic signed [EW-1:0] dr;
        logic signed [EW-1:0] dc;
        logic                 sr_neg;
        logic                 sc_neg;
        logic signed [EW-1:0] err;
    } line_t;

endpackage

/* src/rpe_front.sv */
// Front end: accepts transactions, drops unused modes, queues commands and steps.
// Depends on rpe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "raster_primitive_engine_top_macros.svh"

module rpe_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rpe_pkg::in_item_t in_item,
    output logic             q_valid,
    output rpe_pkg::cmd_t    q_item,
    input  logic             q_pop
);

    rpe_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push;
    rpe_pkg::cmd_t cmd_in;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall &&
                      (in_item.mode != rpe_pkg::MODE_UNUSED);

    assign cmd_in.op     = rpe_pkg::mode_t'(in_item.mode);
    assign cmd_in.row_a  = in_item.row_a;
    assign cmd_in.col_a  = in_item.col_a;
    assign cmd_in.row_b  = in_item.row_b;
    assign cmd_in.col_b  = in_item.col_b;
    assign cmd_in.radius = in_item.radius;

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    `RPE_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, count_reg != 2'd0)
    `RPE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg != 2'd3)
    `RPE_ASSERT_IMP(a_full_no_push, clk, rst_n, in_stall, !push)

endmodule

/* src/rpe_back.sv */
// Back end: shape generators (Bresenham line, Bresenham circle, row scan) and
// the output register. Depends on rpe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "raster_primitive_engine_top_macros.svh"

module rpe_back
#(
    parameter int VISIBLE_COLUMNS = 320,
    parameter int ROW_PITCH       = 512,
    parameter int SCREEN_ROWS     = 240
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  rpe_pkg::cmd_t                     q_item,
    output logic                              q_pop,
    input  logic [rpe_pkg::COLOR_BITS-1:0]    draw_color,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rpe_pkg::pixel_t                   out_pixel
);

    localparam int CW = rpe_pkg::CW;
    localparam int EW = rpe_pkg::EW;
    localparam int DW = rpe_pkg::DW;

    rpe_pkg::shape_t                   kind_reg, kind_next;
    logic [rpe_pkg::COLOR_BITS-1:0]    color_reg, color_next;
    logic                              out_valid_reg, out_valid_next;
    rpe_pkg::pixel_t                   out_reg, out_next;
    rpe_pkg::line_t                    line_reg, line_next;
    logic signed [CW-1:0]              cx_reg, cx_next, cy_reg, cy_next;
    logic signed [DW-1:0]              cd_reg, cd_next;
    logic signed [CW-1:0]              cen_r_reg, cen_r_next, cen_c_reg, cen_c_next;
    logic [2:0]                        oct_reg, oct_next;
    logic [1:0]                        side_reg, side_next;
    logic signed [CW-1:0]              top_reg, top_next, bot_reg, bot_next;
    logic signed [CW-1:0]              left_reg, left_next, right_reg, right_next;

    function automatic rpe_pkg::line_t start_line(input logic signed [CW-1:0] r0,
                                                  input logic signed [CW-1:0] c0,
                                                  input logic signed [CW-1:0] r1,
                                                  input logic signed [CW-1:0] c1);
        rpe_pkg::line_t l;
        logic signed [EW-1:0] dr;
        logic signed [EW-1:0] dcp;
        dr  = (r1 > r0) ? (EW'(r1) - EW'(r0)) : (EW'(r0) - EW'(r1));
        dcp = (c1 > c0) ? (EW'(c1) - EW'(c0)) : (EW'(c0) - EW'(c1));
        l.cur_r  = r0;
        l.cur_c  = c0;
        l.end_r  = r1;
        l.end_c  = c1;
        l.dr     = dr;
        l.dc     = -dcp;
        l.sr_neg = !(r0 < r1);
        l.sc_neg = !(c0 < c1);
        l.err    = dr - dcp;
        return l;
    endfunction

    function automatic rpe_pkg::line_t side_line(input logic [1:0] side,
                                                 input logic signed [CW-1:0] t,
                                                 input logic signed [CW-1:0] b,
                                                 input logic signed [CW-1:0] lf,
                                                 input logic signed [CW-1:0] rt);
        rpe_pkg::line_t l;
        case (side)
            2'd0:    l = start_line(t, lf, t, rt);
            2'd1:    l = start_line(b, lf, b, rt);
            2'd2:    l = start_line(t, lf, b, lf);
            default: l = start_line(t, rt, b, rt);
        endcase
        return l;
    endfunction

    function automatic rpe_pkg::pixel_t emit(input logic signed [CW-1:0] r,
                                             input logic signed [CW-1:0] c,
                                             input logic [rpe_pkg::COLOR_BITS-1:0] col,
                                             input logic last);
        rpe_pkg::pixel_t p;
        logic            on;
        logic [31:0]     addr;
        on = (r >= 0) && (r < $signed(CW'(SCREEN_ROWS))) &&
             (c >= 0) && (c < $signed(CW'(VISIBLE_COLUMNS)));
        addr = 32'(r[CW-2:0]) * 32'(ROW_PITCH) + 32'(c[CW-2:0]);
        p.pixel_address = on ? addr[rpe_pkg::ADDR_BITS-1:0] : '0;
        p.pixel_color   = col;
        p.write_enable  = on;
        p.last_pixel    = last;
        return p;
    endfunction

    // line / outline step terms
    logic                 line_done, line_last, row_move, col_move;
    logic signed [EW:0]   e2;
    logic signed [EW-1:0] err_after;
    assign line_done = (line_reg.cur_r == line_reg.end_r) && (line_reg.cur_c == line_reg.end_c);
    assign line_last = line_done && ((kind_reg == rpe_pkg::K_LINE) || (side_reg == 2'd3));
    assign e2        = $signed({line_reg.err, 1'b0});
    assign row_move  = e2 >= (EW+1)'(line_reg.dc);
    assign col_move  = e2 <= (EW+1)'(line_reg.dr);
    assign err_after = line_reg.err + (row_move ? line_reg.dc : EW'(0))
                                    + (col_move ? line_reg.dr : EW'(0));

    // circle step terms
    logic signed [CW-1:0] circ_r, circ_c, cx_inc, cy_upd;
    logic signed [DW-1:0] cd_upd;
    logic                 cd_le0, circ_last;
    assign cd_le0 = cd_reg <= 0;
    assign cx_inc = cx_reg + CW'(1);
    assign cy_upd = cd_le0 ? cy_reg : (cy_reg - CW'(1));
    assign cd_upd = cd_le0 ? (cd_reg + (DW'(cx_reg) <<< 2) + DW'(6))
                           : (cd_reg + ((DW'(cx_reg) - DW'(cy_reg)) <<< 2) + DW'(10));
    assign circ_last = (oct_reg == 3'd7) && (cx_inc > cy_upd);

    always_comb
    begin
        case (oct_reg)
            3'd0:    begin circ_r = cen_r_reg + cx_reg; circ_c = cen_c_reg + cy_reg; end
            3'd1:    begin circ_r = cen_r_reg - cx_reg; circ_c = cen_c_reg + cy_reg; end
            3'd2:    begin circ_r = cen_r_reg + cx_reg; circ_c = cen_c_reg - cy_reg; end
            3'd3:    begin circ_r = cen_r_reg - cx_reg; circ_c = cen_c_reg - cy_reg; end
            3'd4:    begin circ_r = cen_r_reg + cy_reg; circ_c = cen_c_reg + cx_reg; end
            3'd5:    begin circ_r = cen_r_reg - cy_reg; circ_c = cen_c_reg + cx_reg; end
            3'd6:    begin circ_r = cen_r_reg + cy_reg; circ_c = cen_c_reg - cx_reg; end
            default: begin circ_r = cen_r_reg - cy_reg; circ_c = cen_c_reg - cx_reg; end
        endcase
    end

    // scan step terms
    logic                 scan_last;
    logic signed [CW-1:0] scan_col_inc;
    assign scan_last    = (line_reg.cur_r == bot_reg) && (line_reg.cur_c == right_reg);
    assign scan_col_inc = line_reg.cur_c + CW'(1);

    // rectangle corners of the incoming command
    logic signed [CW-1:0] in_top, in_bot, in_left, in_right;
    assign in_top   = (q_item.row_a < q_item.row_b) ? CW'(q_item.row_a) : CW'(q_item.row_b);
    assign in_bot   = (q_item.row_a < q_item.row_b) ? CW'(q_item.row_b) : CW'(q_item.row_a);
    assign in_left  = (q_item.col_a < q_item.col_b) ? CW'(q_item.col_a) : CW'(q_item.col_b);
    assign in_right = (q_item.col_a < q_item.col_b) ? CW'(q_item.col_b) : CW'(q_item.col_a);

    assign q_pop     = q_valid && !(out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_pixel = out_reg;

    always_comb
    begin
        kind_next      = kind_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        line_next      = line_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cd_next        = cd_reg;
        cen_r_next     = cen_r_reg;
        cen_c_next     = cen_c_reg;
        oct_next       = oct_reg;
        side_next      = side_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        if (q_pop)
        begin
            if (q_item.op == rpe_pkg::MODE_STEP)
            begin
                unique case (kind_reg)
                    rpe_pkg::K_LINE, rpe_pkg::K_OUTLINE:
                    begin
                        out_next       = emit(line_reg.cur_r, line_reg.cur_c, color_reg,
                                              line_last);
                        out_valid_next = 1'b1;
                        if (line_last)
                        begin
                            kind_next = rpe_pkg::K_IDLE;
                        end
                        else if (line_done)
                        begin
                            side_next = side_reg + 2'd1;
                            line_next = side_line(side_reg + 2'd1, top_reg, bot_reg,
                                                  left_reg, right_reg);
                        end
                        else
                        begin
                            line_next.err = err_after;
                            if (row_move)
                            begin
                                line_next.cur_r = line_reg.sr_neg ? line_reg.cur_r - CW'(1)
                                                                  : line_reg.cur_r + CW'(1);
                            end
                            if (col_move)
                            begin
                                line_next.cur_c = line_reg.sc_neg ? line_reg.cur_c - CW'(1)
                                                                  : line_reg.cur_c + CW'(1);
                            end
                        end
                    end
                    rpe_pkg::K_CIRCLE:
                    begin
                        out_next       = emit(circ_r, circ_c, color_reg, circ_last);
                        out_valid_next = 1'b1;
                        oct_next       = oct_reg + 3'd1;
                        if (oct_reg == 3'd7)
                        begin
                            cd_next = cd_upd;
                            cx_next = cx_inc;
                            cy_next = cy_upd;
                        end
                        if (circ_last)
                        begin
                            kind_next = rpe_pkg::K_IDLE;
                        end
                    end
                    rpe_pkg::K_SCAN:
                    begin
                        out_next       = emit(line_reg.cur_r, line_reg.cur_c, color_reg,
                                              scan_last);
                        out_valid_next = 1'b1;
                        if (scan_last)
                        begin
                            kind_next = rpe_pkg::K_IDLE;
                        end
                        else if (scan_col_inc > right_reg)
                        begin
                            line_next.cur_c = left_reg;
                            line_next.cur_r = line_reg.cur_r + CW'(1);
                        end
                        else
                        begin
                            line_next.cur_c = scan_col_inc;
                        end
                    end
                    default:
                    begin
                        kind_next = rpe_pkg::K_IDLE;
                    end
                endcase
            end
            else
            begin
                color_next = (q_item.op == rpe_pkg::MODE_CLEAR) ? rpe_pkg::CLEAR_COLOR
                                                                : draw_color;
                unique case (q_item.op)
                    rpe_pkg::MODE_LINE:
                    begin
                        kind_next = rpe_pkg::K_LINE;
                        line_next = start_line(CW'(q_item.row_a), CW'(q_item.col_a),
                                               CW'(q_item.row_b), CW'(q_item.col_b));
                    end
                    rpe_pkg::MODE_CIRCLE:
                    begin
                        if (q_item.radius < 0)
                        begin
                            kind_next = rpe_pkg::K_IDLE;
                        end
                        else
                        begin
                            kind_next  = rpe_pkg::K_CIRCLE;
                            cen_r_next = CW'(q_item.row_a);
                            cen_c_next = CW'(q_item.col_a);
                            cx_next    = '0;
                            cy_next    = CW'(q_item.radius);
                            cd_next    = $signed(DW'(3)) - ($signed(DW'(q_item.radius)) <<< 1);
                            oct_next   = 3'd0;
                        end
                    end
                    rpe_pkg::MODE_OUTLINE:
                    begin
                        kind_next  = rpe_pkg::K_OUTLINE;
                        top_next   = in_top;
                        bot_next   = in_bot;
                        left_next  = in_left;
                        right_next = in_right;
                        side_next  = 2'd0;
                        line_next  = side_line(2'd0, in_top, in_bot, in_left, in_right);
                    end
                    rpe_pkg::MODE_RECT:
                    begin
                        kind_next       = rpe_pkg::K_SCAN;
                        top_next        = in_top;
                        bot_next        = in_bot;
                        left_next       = in_left;
                        right_next      = in_right;
                        line_next.cur_r = in_top;
                        line_next.cur_c = in_left;
                    end
                    rpe_pkg::MODE_FILL, rpe_pkg::MODE_CLEAR:
                    begin
                        kind_next       = rpe_pkg::K_SCAN;
                        top_next        = '0;
                        bot_next        = CW'(SCREEN_ROWS - 1);
                        left_next       = '0;
                        right_next      = CW'(VISIBLE_COLUMNS - 1);
                        line_next.cur_r = '0;
                        line_next.cur_c = '0;
                    end
                    default:
                    begin
                        color_next = color_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= rpe_pkg::K_IDLE;
            color_reg     <= rpe_pkg::RESET_COLOR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg      <= kind_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        line_reg  <= line_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cd_reg    <= cd_next;
        cen_r_reg <= cen_r_next;
        cen_c_reg <= cen_c_next;
        oct_reg   <= oct_next;
        side_reg  <= side_next;
        top_reg   <= top_next;
        bot_reg   <= bot_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    logic chk_clip_ok, chk_idle_step, chk_cmd_pop;
    assign chk_clip_ok   = out_reg.write_enable || (out_reg.pixel_address == '0);
    assign chk_idle_step = q_pop && (q_item.op == rpe_pkg::MODE_STEP) &&
                           (kind_reg == rpe_pkg::K_IDLE);
    assign chk_cmd_pop   = q_pop && (q_item.op != rpe_pkg::MODE_STEP);

    `RPE_ASSERT_IMP(a_clip_zero_addr, clk, rst_n, out_valid_reg, chk_clip_ok)
    `RPE_ASSERT_NXT(a_idle_step_quiet, clk, rst_n, chk_idle_step, !out_valid_reg)
    `RPE_ASSERT_NXT(a_cmd_quiet, clk, rst_n, chk_cmd_pop, !out_valid_reg)

endmodule

/* src/raster_primitive_engine_top.sv */
// Raster primitive engine: one pixel transaction per step of an active shape.
// A step is held in the front-end queue, then its pixel is registered in the
// back-end output register until taken. Throughput one transaction per cycle,
// set by the back-end generator, which retires one queued transaction per cycle
// while out_stall is low. Reset (rst_n low, asynchronous) empties the queue,
// idles the generator and sets draw_color to 0xFFFF.
`timescale 1ns / 1ps

module raster_primitive_engine_top
#(
    parameter int VISIBLE_COLUMNS = 320,
    parameter int ROW_PITCH       = 512,
    parameter int SCREEN_ROWS     = 240
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input transactions: commands and steps
    input  logic                            in_valid,
    output logic                            in_stall,
    input  rpe_pkg::in_item_t               in_item,
    // output transactions: pixel writes
    output logic                            out_valid,
    input  logic                            out_stall,
    output rpe_pkg::pixel_t                 out_pixel,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpe_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [rpe_pkg::COLOR_BITS-1:0] draw_color_reg, draw_color_next;
    logic                           sel_draw_color;
    logic                           cfg_write;
    logic                           q_valid;
    logic                           q_pop;
    rpe_pkg::cmd_t                  q_item;

    // Register map: draw_color is the only register, word at byte offset 0.
    assign pready         = 1'b1;
    assign sel_draw_color = (paddr[rpe_pkg::PADDR_BITS-1] == 1'b0);
    assign cfg_write      = psel && penable && pwrite && pready;

    always_comb
    begin
        draw_color_next = draw_color_reg;
        if (cfg_write && sel_draw_color)
        begin
            draw_color_next = pwdata[rpe_pkg::COLOR_BITS-1:0];
        end
    end

    // Read back draw_color; other offsets read as zero.
    assign prdata = sel_draw_color ? {16'h0000, draw_color_reg} : 32'h0000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg <= rpe_pkg::RESET_COLOR;
        end
        else
        begin
            draw_color_reg <= draw_color_next;
        end
    end

    // Front end: take in transactions, drop the unused mode, hold up to two.
    rpe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back end: run the shape generators and hold the pixel until taken.
    rpe_back
    #(
        .VISIBLE_COLUMNS (VISIBLE_COLUMNS),
        .ROW_PITCH       (ROW_PITCH),
        .SCREEN_ROWS     (SCREEN_ROWS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .draw_color (draw_color_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_pixel  (out_pixel)
    );

endmodule
